@@ src/wmm_pkg.sv @@
// Shared constants, the sequencer state type and the extreme-tracker command
// struct of the windowed min/max/mean core. No dependencies.
`default_nettype none

package wmm_pkg;

    // Sample field widths and the packed ring word {time, rate}.
    localparam int RATE_W = 14;
    localparam int TIME_W = 16;
    localparam int WORD_W = RATE_W + TIME_W;

    // Stream payload widths.
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 96;

    // Quotient bits produced by the serial divider; a mean never exceeds 16 bits.
    localparam int MEAN_Q_W = 16;

    localparam int DEFAULT_WINDOW = 128;

    // Item kinds carried in tuser.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_SCAN_END,
        ST_RATE_START,
        ST_RATE_WAIT,
        ST_TIME_START,
        ST_TIME_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic apply;
        logic scan;
    } ext_cmd_t;

endpackage

`default_nettype wire

@@ src/wmm_ring_mem.sv @@
// Single-port ring store holding one {time, rate} word per window slot.
// One access per cycle, registered read data. Depends on nothing.
`default_nettype none

module wmm_ring_mem #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 30,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ src/wmm_divider.sv @@
// Serial restoring divider: one quotient bit per cycle, QUO_W quotient bits per run.
// Uses nothing from the package.
`default_nettype none

module wmm_divider #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 8,
    parameter int QUO_W      = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic      [QUO_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(QUO_W);

    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [QUO_W-1:0]     low_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    // The quotient is known to fit QUO_W bits, so the upper dividend bits
    // seed the partial remainder and only the low QUO_W bits are walked.
    always_comb
    begin
        trial    = {rem_reg, low_reg[QUO_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUO_W]);
            low_reg     <= dividend[QUO_W-1:0];
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

`default_nettype wire

@@ src/wmm_extreme.sv @@
// Minimum and maximum tracker of one channel: recorded slots and values,
// updated by a new sample or by rescan entries. Uses ext_cmd_t from wmm_pkg.
`default_nettype none

module wmm_extreme
    import wmm_pkg::*;
#(
    parameter int DATA_W = 14,
    parameter int ADDR_W = 7
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ext_cmd_t          cmd,
    input  wire logic [ADDR_W-1:0] slot,
    input  wire logic [DATA_W-1:0] value,
    output logic                   need,
    output logic      [DATA_W-1:0] lo_val,
    output logic      [DATA_W-1:0] hi_val
);

    logic              lo_valid_reg;
    logic              hi_valid_reg;
    logic [ADDR_W-1:0] lo_slot_reg;
    logic [ADDR_W-1:0] hi_slot_reg;
    logic [DATA_W-1:0] lo_val_reg;
    logic [DATA_W-1:0] hi_val_reg;
    logic              need_reg;
    logic              take_lo;
    logic              take_hi;

    always_comb
    begin
        need    = (lo_valid_reg && (lo_slot_reg == slot)) ||
                  (hi_valid_reg && (hi_slot_reg == slot));
        take_lo = (value != '0) && (!lo_valid_reg || (value < lo_val_reg));
        take_hi = (value != '0) && (!hi_valid_reg || (value > hi_val_reg));
    end

    // When the overwritten slot held an extreme, both extremes are dropped
    // and rebuilt by the rescan, which also sees the newly written sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_valid_reg <= 1'b0;
            hi_valid_reg <= 1'b0;
            lo_slot_reg  <= '0;
            hi_slot_reg  <= '0;
            lo_val_reg   <= '0;
            hi_val_reg   <= '0;
            need_reg     <= 1'b0;
        end
        else if (cmd.clear || (cmd.apply && need))
        begin
            lo_valid_reg <= 1'b0;
            hi_valid_reg <= 1'b0;
            lo_val_reg   <= '0;
            hi_val_reg   <= '0;
            need_reg     <= cmd.apply;
        end
        else if (cmd.apply || (cmd.scan && need_reg))
        begin
            if (cmd.apply)
            begin
                need_reg <= 1'b0;
            end
            if (take_lo)
            begin
                lo_valid_reg <= 1'b1;
                lo_slot_reg  <= slot;
                lo_val_reg   <= value;
            end
            if (take_hi)
            begin
                hi_valid_reg <= 1'b1;
                hi_slot_reg  <= slot;
                hi_val_reg   <= value;
            end
        end
    end

    assign lo_val = lo_val_reg;
    assign hi_val = hi_val_reg;

endmodule

`default_nettype wire

@@ src/windowed_min_max_mean_core.sv @@
// Top level of the windowed min/max/mean core: sequencer, running sums and
// counts, output register. Depends on wmm_pkg, wmm_ring_mem, wmm_divider, wmm_extreme.
`default_nettype none

// The core keeps the last WINDOW samples of a frame rate and a processing time
// and answers every input transaction with exactly one output transaction that
// carries, per channel, the least and greatest nonzero sample of the window and
// the truncated mean of the nonzero samples (zero marks an absent sample, and
// every field is 0 when a channel has no sample). A sample transaction reads
// the slot being replaced as it is taken, then writes it and updates the
// running sums, then runs two passes of the one serial divider, rate first.
// When the replaced slot held the recorded minimum or maximum of a channel,
// a rescan reads every slot through the single ring port before the divider
// passes. A clear transaction zeroes the ring one slot per cycle; the same
// clearing pass runs after reset, and s_tready stays low until it ends. The
// core takes a transaction only while idle, but a finished result waits in the
// output register, so the next transaction may be accepted before the previous
// result is taken.
module windowed_min_max_mean_core
    import wmm_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [13:0] rate_sample, [29:14] time_sample, [31:30] zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [0] kind
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [13:0] rate_min, [27:14] rate_max, [41:28] rate_mean, [57:42] time_min,
    // [73:58] time_max, [89:74] time_mean, [95:90] zero
    output logic      [OUT_DATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int RSUM_W = RATE_W + ADDR_W;
    localparam int TSUM_W = TIME_W + ADDR_W;
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW - 1);

    state_t state_reg;
    state_t state_next;

    logic              accept;
    logic              out_free;

    logic [RATE_W-1:0] in_rate_reg;
    logic [TIME_W-1:0] in_time_reg;

    logic [ADDR_W-1:0] write_slot_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] scan_addr_reg;
    logic [ADDR_W-1:0] scan_slot_reg;
    logic              scan_dv_reg;
    logic              clear_pend_reg;

    logic [RSUM_W-1:0] rate_sum_reg;
    logic [TSUM_W-1:0] time_sum_reg;
    logic [CNT_W-1:0]  rate_count_reg;
    logic [CNT_W-1:0]  time_count_reg;
    logic [RATE_W-1:0] rate_mean_reg;
    logic [TIME_W-1:0] time_mean_reg;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Ring port.
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;
    logic [RATE_W-1:0] old_rate;
    logic [TIME_W-1:0] old_time;

    // Extreme trackers.
    ext_cmd_t          ext_cmd;
    logic [ADDR_W-1:0] ext_slot;
    logic [RATE_W-1:0] rate_ext_value;
    logic [TIME_W-1:0] time_ext_value;
    logic              rate_need;
    logic              time_need;
    logic [RATE_W-1:0] rate_min;
    logic [RATE_W-1:0] rate_max;
    logic [TIME_W-1:0] time_min;
    logic [TIME_W-1:0] time_max;

    // Divider.
    logic                div_start;
    logic [TSUM_W-1:0]   div_dividend;
    logic [CNT_W-1:0]    div_divisor;
    logic                div_done;
    logic [MEAN_Q_W-1:0] div_quotient;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign old_rate = mem_rdata[RATE_W-1:0];
    assign old_time = mem_rdata[WORD_W-1:RATE_W];

    wmm_ring_mem #(
        .DEPTH  (WINDOW),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    wmm_extreme #(
        .DATA_W (RATE_W),
        .ADDR_W (ADDR_W)
    ) u_rate_ext (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ext_cmd),
        .slot   (ext_slot),
        .value  (rate_ext_value),
        .need   (rate_need),
        .lo_val (rate_min),
        .hi_val (rate_max)
    );

    wmm_extreme #(
        .DATA_W (TIME_W),
        .ADDR_W (ADDR_W)
    ) u_time_ext (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ext_cmd),
        .slot   (ext_slot),
        .value  (time_ext_value),
        .need   (time_need),
        .lo_val (time_min),
        .hi_val (time_max)
    );

    wmm_divider #(
        .DIVIDEND_W (TSUM_W),
        .DIVISOR_W  (CNT_W),
        .QUO_W      (MEAN_Q_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_SLOT)
                begin
                    state_next = clear_pend_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_tuser[0] == KIND_CLEAR) ? ST_CLEAR : ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = (rate_need || time_need) ? ST_SCAN : ST_RATE_START;
            end
            ST_SCAN:
            begin
                if (scan_addr_reg == LAST_SLOT)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:   state_next = ST_RATE_START;
            ST_RATE_START: state_next = ST_RATE_WAIT;
            ST_RATE_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_TIME_START;
                end
            end
            ST_TIME_START: state_next = ST_TIME_WAIT;
            ST_TIME_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Datapath controls decoded from the sequencer state.
    always_comb
    begin
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = write_slot_reg;
        mem_wdata      = '0;
        ext_cmd        = '0;
        ext_slot       = scan_slot_reg;
        rate_ext_value = old_rate;
        time_ext_value = old_time;
        div_start      = 1'b0;
        div_dividend   = TSUM_W'(rate_sum_reg);
        div_divisor    = rate_count_reg;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_addr_reg;
            end
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                // The replaced slot is read while the transaction is taken.
                mem_re        = accept;
                ext_cmd.clear = accept && (s_tuser[0] == KIND_CLEAR);
            end
            ST_UPDATE:
            begin
                mem_we         = 1'b1;
                mem_wdata      = {in_time_reg, in_rate_reg};
                ext_cmd.apply  = 1'b1;
                ext_slot       = write_slot_reg;
                rate_ext_value = in_rate_reg;
                time_ext_value = in_time_reg;
            end
            ST_SCAN:
            begin
                mem_re       = 1'b1;
                mem_addr     = scan_addr_reg;
                ext_cmd.scan = scan_dv_reg;
            end
            ST_SCAN_END:
            begin
                ext_cmd.scan = scan_dv_reg;
            end
            ST_RATE_START:
            begin
                div_start = 1'b1;
            end
            ST_TIME_START:
            begin
                div_start    = 1'b1;
                div_dividend = time_sum_reg;
                div_divisor  = time_count_reg;
            end
            ST_RATE_WAIT, ST_TIME_WAIT, ST_DONE:
            begin
                div_divisor = rate_count_reg;
            end
            default:
            begin
                div_divisor = rate_count_reg;
            end
        endcase
    end

    // Control registers: sequencer, slot pointers, sums and counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            write_slot_reg <= '0;
            clr_addr_reg   <= '0;
            scan_addr_reg  <= '0;
            scan_dv_reg    <= 1'b0;
            clear_pend_reg <= 1'b0;
            rate_sum_reg   <= '0;
            time_sum_reg   <= '0;
            rate_count_reg <= '0;
            time_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            scan_dv_reg <= (state_reg == ST_SCAN);

            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= (clr_addr_reg == LAST_SLOT) ? '0
                                                            : clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_SLOT)
                begin
                    clear_pend_reg <= 1'b0;
                end
            end

            if (accept && (s_tuser[0] == KIND_CLEAR))
            begin
                clear_pend_reg <= 1'b1;
                write_slot_reg <= '0;
                rate_sum_reg   <= '0;
                time_sum_reg   <= '0;
                rate_count_reg <= '0;
                time_count_reg <= '0;
            end

            if (state_reg == ST_UPDATE)
            begin
                // A zero sample adds nothing to a sum, so only the counts
                // need the absent-sample test.
                rate_sum_reg   <= rate_sum_reg - RSUM_W'(old_rate) + RSUM_W'(in_rate_reg);
                time_sum_reg   <= time_sum_reg - TSUM_W'(old_time) + TSUM_W'(in_time_reg);
                rate_count_reg <= rate_count_reg - CNT_W'(old_rate != '0)
                                  + CNT_W'(in_rate_reg != '0);
                time_count_reg <= time_count_reg - CNT_W'(old_time != '0)
                                  + CNT_W'(in_time_reg != '0);
                write_slot_reg <= (write_slot_reg == LAST_SLOT) ? '0
                                                                : write_slot_reg + ADDR_W'(1);
                scan_addr_reg  <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
            end

            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_rate_reg <= s_tdata[RATE_W-1:0];
            in_time_reg <= s_tdata[RATE_W+TIME_W-1:RATE_W];
        end

        scan_slot_reg <= scan_addr_reg;

        if (accept && (s_tuser[0] == KIND_CLEAR))
        begin
            rate_mean_reg <= '0;
            time_mean_reg <= '0;
        end

        // An empty channel divides by zero; its mean is forced to zero.
        if ((state_reg == ST_RATE_WAIT) && div_done)
        begin
            rate_mean_reg <= (rate_count_reg == '0) ? '0 : div_quotient[RATE_W-1:0];
        end
        if ((state_reg == ST_TIME_WAIT) && div_done)
        begin
            time_mean_reg <= (time_count_reg == '0) ? '0 : div_quotient[TIME_W-1:0];
        end

        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tdata_reg <= {6'b0, time_mean_reg, time_max, time_min,
                            rate_mean_reg, rate_max, rate_min};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ sim/wmm_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for windowed_min_max_mean_core: watches both stream channels,
// predicts the window statistics and compares each output transaction.
// Depends on wmm_pkg.

module wmm_checker
    import wmm_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    output int                         fail_count,
    output int                         pending
);

    localparam int RATE_CH = 0;
    localparam int TIME_CH = 1;

    // Same layout as m_tdata, lowest field last.
    typedef struct packed {
        logic [5:0]        pad;
        logic [TIME_W-1:0] time_mean;
        logic [TIME_W-1:0] time_max;
        logic [TIME_W-1:0] time_min;
        logic [RATE_W-1:0] rate_mean;
        logic [RATE_W-1:0] rate_max;
        logic [RATE_W-1:0] rate_min;
    } window_stats_t;

    // Both channels are held 16 bits wide; extreme entries are
    // rate min, rate max, time min, time max.
    logic [15:0] ring [2][WINDOW];
    int unsigned chan_sum [2];
    int unsigned chan_count [2];
    bit          ext_ok [4];
    int          ext_slot [4];
    logic [15:0] ext_val [4];
    int          write_slot;

    window_stats_t expected_stats_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void wipe_window();
        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < WINDOW; i++)
                ring[c][i] = '0;
            chan_sum[c]   = 0;
            chan_count[c] = 0;
        end
        for (int e = 0; e < 4; e++) begin
            ext_ok[e]   = 1'b0;
            ext_slot[e] = 0;
            ext_val[e]  = '0;
        end
        write_slot = 0;
    endfunction

    // Full pass over the ring; on a tie the lowest slot keeps the extreme.
    function automatic void rescan_channel(int ch);
        int          lo;
        int          hi;
        logic [15:0] v;
        lo = 2 * ch;
        hi = lo + 1;
        ext_ok[lo] = 1'b0;  ext_slot[lo] = 0;  ext_val[lo] = '0;
        ext_ok[hi] = 1'b0;  ext_slot[hi] = 0;  ext_val[hi] = '0;
        for (int i = 0; i < WINDOW; i++) begin
            v = ring[ch][i];
            if (v != 0) begin
                if (!ext_ok[lo] || v < ext_val[lo]) begin
                    ext_ok[lo] = 1'b1;  ext_slot[lo] = i;  ext_val[lo] = v;
                end
                if (!ext_ok[hi] || v > ext_val[hi]) begin
                    ext_ok[hi] = 1'b1;  ext_slot[hi] = i;  ext_val[hi] = v;
                end
            end
        end
    endfunction

    function automatic void enter_sample(int ch, logic [15:0] nv);
        int          lo;
        int          hi;
        int          s;
        logic [15:0] old;
        bit          need;
        lo  = 2 * ch;
        hi  = lo + 1;
        s   = write_slot;
        old = ring[ch][s];
        if (old != 0) begin
            chan_sum[ch]   -= old;
            chan_count[ch] -= 1;
        end
        ring[ch][s] = nv;
        if (nv != 0) begin
            chan_sum[ch]   += nv;
            chan_count[ch] += 1;
        end
        need = (ext_ok[lo] && ext_slot[lo] == s) || (ext_ok[hi] && ext_slot[hi] == s);
        // The comparison reads the ring after the write, so a new value that
        // lands on the recorded slot never wins here; the rescan settles it.
        if (nv != 0) begin
            if (!ext_ok[lo] || nv < ring[ch][ext_slot[lo]]) begin
                ext_ok[lo] = 1'b1;  ext_slot[lo] = s;  ext_val[lo] = nv;
            end
            if (!ext_ok[hi] || nv > ring[ch][ext_slot[hi]]) begin
                ext_ok[hi] = 1'b1;  ext_slot[hi] = s;  ext_val[hi] = nv;
            end
        end
        if (need)
            rescan_channel(ch);
    endfunction

    function automatic window_stats_t predict_stats(logic kind, logic [RATE_W-1:0] rate,
                                                    logic [TIME_W-1:0] tm);
        window_stats_t r;
        logic [31:0]   q;
        if (kind == KIND_CLEAR) begin
            wipe_window();
        end else begin
            enter_sample(RATE_CH, {2'b00, rate});
            enter_sample(TIME_CH, tm);
            write_slot = (write_slot + 1 >= WINDOW) ? 0 : write_slot + 1;
        end
        r = '0;
        r.rate_min = ext_val[0][RATE_W-1:0];
        r.rate_max = ext_val[1][RATE_W-1:0];
        r.time_min = ext_val[2];
        r.time_max = ext_val[3];
        q = (chan_count[RATE_CH] != 0) ? chan_sum[RATE_CH] / chan_count[RATE_CH] : 0;
        r.rate_mean = q[RATE_W-1:0];
        q = (chan_count[TIME_CH] != 0) ? chan_sum[TIME_CH] / chan_count[TIME_CH] : 0;
        r.time_mean = q[TIME_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Output side first, so a result taken at the same edge as a new input
    // transaction is matched against the older expectation.
    always @(posedge clk or negedge rst_n) begin
        window_stats_t want;
        window_stats_t got;
        if (!rst_n) begin
            wipe_window();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_stats_q.size() == 0) begin
                    $display("%0t: output transaction with no expected result, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_stats_q.pop_front();
                    check_field("rate_min", want.rate_min, got.rate_min);
                    check_field("rate_max", want.rate_max, got.rate_max);
                    check_field("rate_mean", want.rate_mean, got.rate_mean);
                    check_field("time_min", want.time_min, got.time_min);
                    check_field("time_max", want.time_max, got.time_max);
                    check_field("time_mean", want.time_mean, got.time_mean);
                    check_field("padding", want.pad, got.pad);
                end
            end
            if (s_tvalid && s_tready)
                expected_stats_q.insert(expected_stats_q.size(),
                                        predict_stats(s_tuser[0], s_tdata[RATE_W-1:0],
                                                      s_tdata[WORD_W-1:RATE_W]));
            pending = expected_stats_q.size();
        end
    end

endmodule

@@ sim/tb_windowed_min_max_mean_core.sv @@
`timescale 1ns / 1ps
// Top of the windowed_min_max_mean_core regression: clock, reset, stimulus and
// receiver back-pressure; checking lives in wmm_checker. Depends on wmm_pkg.

module tb_windowed_min_max_mean_core;
    import wmm_pkg::*;

    localparam int WINDOW       = DEFAULT_WINDOW;
    localparam int RANDOM_ITEMS = 750;
    // Long receiver hold-off, well past the time to fill the output register.
    localparam int HOLD_CYCLES  = 800;
    // The run's time limit in ns, many times the worst case of one transaction.
    localparam int LIMIT_NS     = 10_000_000;

    localparam logic [RATE_W-1:0] RATE_FULL = '1;
    localparam logic [TIME_W-1:0] TIME_FULL = '1;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending;

    // Idle percentages for the current phase and the hold-off request counter.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    always #5 clk = ~clk;

    windowed_min_max_mean_core #(
        .WINDOW (WINDOW)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wmm_checker #(
        .WINDOW (WINDOW)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random stalls at the phase rate, plus a long hold-off whenever
    // the stimulus raises a new request. The hold is counted here.
    always @(negedge clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offers one transaction, idling first at the phase rate, and returns at
    // the rising edge where it is taken.
    task automatic offer_item(logic kind, logic [RATE_W-1:0] rate, logic [TIME_W-1:0] tm);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(IN_DATA_W - WORD_W){1'b0}}, tm, rate};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Holds the sender back until every expected result has been taken.
    // The offer is withdrawn first so the last transaction is not taken twice.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Sample value for the current stretch of the random part:
    // 0 mixed, 1 mostly absent, 2 few distinct values (many ties),
    // 3 rising ramp (minimum in the oldest slot until it wraps), 4 falling ramp.
    function automatic logic [15:0] pick_value(int mode, int idx, logic [15:0] full);
        int          r;
        int unsigned step;
        logic [15:0] v;
        r    = $urandom_range(99);
        step = (idx * 97) % full;
        case (mode)
            1: v = (r < 85) ? 16'd0 : 16'($urandom_range(full, 1));
            2: v = (r < 10) ? 16'd0 : 16'($urandom_range(4, 1));
            3: v = (r < 5) ? 16'd0 : 16'(step + 1);
            4: v = (r < 5) ? 16'd0 : 16'(full - step);
            default: begin
                if (r < 10)
                    v = '0;
                else if (r < 18)
                    v = full;
                else if (r < 26)
                    v = 16'd1;
                else if (r < 40)
                    v = 16'($urandom_range(8, 1));
                else
                    v = 16'($urandom_range(full, 0));
            end
        endcase
        return v;
    endfunction

    initial begin
        #(LIMIT_NS);
        $display("windowed_min_max_mean_core regression: fail");
        $finish;
    end

    initial begin
        int phase;
        int new_phase;
        int mode;
        int stretch_left;
        phase        = 0;
        mode         = 0;
        stretch_left = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. The first transaction waits out the clearing pass.
        offer_item(KIND_SAMPLE, '0, '0);              // empty window, both absent
        offer_item(KIND_SAMPLE, RATE_FULL, TIME_FULL);
        offer_item(KIND_SAMPLE, 14'd1, 16'd1);
        offer_item(KIND_SAMPLE, '0, 16'd500);         // rate absent only
        offer_item(KIND_SAMPLE, 14'd800, '0);         // time absent only
        offer_item(KIND_SAMPLE, RATE_FULL, TIME_FULL); // tie on the maximum
        offer_item(KIND_SAMPLE, 14'd1, 16'd1);        // tie on the minimum
        offer_item(KIND_SAMPLE, 14'h2AAA, 16'h5555);
        offer_item(KIND_SAMPLE, 14'h1555, 16'hAAAA);
        offer_item(KIND_CLEAR, RATE_FULL, TIME_FULL);  // clear ignores its sample fields
        offer_item(KIND_SAMPLE, '0, '0);
        offer_item(KIND_CLEAR, '0, '0);
        offer_item(KIND_CLEAR, 14'h2AAA, 16'h5555);   // back-to-back clears
        for (int i = 0; i < 6; i++)
            offer_item(KIND_SAMPLE, RATE_FULL, TIME_FULL); // full-scale sums and means
        offer_item(KIND_SAMPLE, 14'd3, 16'd7);
        offer_item(KIND_SAMPLE, 14'd2, 16'd65534);
        drain();

        // Random part in four idling phases; the sender drains between them.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            new_phase = (i * 4) / RANDOM_ITEMS;
            if (new_phase != phase) begin
                phase = new_phase;
                drain();
                case (phase)
                    1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
                    2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
                    default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
                endcase
            end
            // Long receiver hold-off while the sender keeps offering.
            if (i == 60)
                hold_req++;
            if (stretch_left == 0) begin
                mode         = $urandom_range(4);
                stretch_left = $urandom_range(200, 20);
            end
            stretch_left--;
            if ($urandom_range(119) == 0)
                offer_item(KIND_CLEAR, RATE_W'($urandom), TIME_W'($urandom));
            else
                offer_item(KIND_SAMPLE, RATE_W'(pick_value(mode, i, 16'(RATE_FULL))),
                           pick_value(mode, i, TIME_FULL));
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        drain();
        repeat (WINDOW + 60) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("windowed_min_max_mean_core regression: pass");
        else
            $display("windowed_min_max_mean_core regression: fail");
        $finish;
    end

endmodule
